/* hw/rtl/stt_pkg.sv */
package stt_pkg;

	// Position counter widths
	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;

	// Result queue depth: two beats from one byte on top of up to two still waiting
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Byte codes the lexer reacts to
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	// Lexer modes, one-hot
	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_COMMENT = 5'b00010,
		MODE_WORD    = 5'b00100,
		MODE_STRING  = 5'b01000,
		MODE_ESCAPE  = 5'b10000
	} stt_mode_t;

	// One result beat
	typedef struct packed {
		logic [7:0]             text_byte;
		logic                   has_byte;
		logic                   token_start;
		logic                   token_end;
		logic                   quoted;
		logic [LINE_BITS-1:0]   token_line;
		logic [COLUMN_BITS-1:0] token_column;
		logic                   last;
	} stt_result_t;

	// Results caused by one byte, handed from lexer to queue
	typedef struct packed {
		logic [1:0]  count;
		stt_result_t r1;
		stt_result_t r0;
	} stt_batch_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic logic is_word_delim(input logic [7:0] c);
		return is_space(c) || c == CH_QUOTE || c == CH_LBRACK ||
			c == CH_RBRACK || c == CH_HASH;
	endfunction

endpackage

/* hw/rtl/stt_in_if.sv */
interface stt_in_if;
	import stt_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);

endinterface

/* hw/rtl/stt_out_if.sv */
interface stt_out_if;
	import stt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [7:0]             text_byte;
	logic                   has_byte;
	logic                   token_start;
	logic                   token_end;
	logic                   quoted;
	logic [LINE_BITS-1:0]   token_line;
	logic [COLUMN_BITS-1:0] token_column;
	logic                   last;

	modport source (
		output valid, output text_byte, output has_byte, output token_start,
		output token_end, output quoted, output token_line, output token_column,
		output last, input ready
	);
	modport sink (
		input valid, input text_byte, input has_byte, input token_start,
		input token_end, input quoted, input token_line, input token_column,
		input last, output ready
	);

endinterface

/* hw/rtl/stt_lexer.sv */
module stt_lexer import stt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output stt_batch_t batch
);

	typedef struct packed {
		logic        emit;
		stt_result_t res;
		stt_mode_t   mode;
	} stt_idle_t;

	stt_mode_t              mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d, line_adv;
	logic [COLUMN_BITS-1:0] col_q, col_d, col_adv;
	logic                   is_lf;
	stt_idle_t              idle_r;
	stt_result_t            r0, r1;
	logic [1:0]             cnt;
	logic [7:0]             esc_byte;

	// Byte that arrives between tokens: opens a token, a comment, or nothing
	function automatic stt_idle_t idle_step(
		input logic [7:0]             c,
		input logic [LINE_BITS-1:0]   l,
		input logic [COLUMN_BITS-1:0] k
	);
		stt_idle_t o;
		o = '0;
		o.mode = MODE_IDLE;
		if (is_space(c)) begin
			o.emit = 1'b0;
		end else if (c == CH_HASH) begin
			o.mode = MODE_COMMENT;
		end else begin
			o.emit               = 1'b1;
			o.res.token_start    = 1'b1;
			o.res.token_line     = l;
			o.res.token_column   = k;
			if (c == CH_QUOTE) begin
				o.res.quoted = 1'b1;
				o.mode       = MODE_STRING;
			end else if (c == CH_LBRACK || c == CH_RBRACK) begin
				o.res.text_byte = c;
				o.res.has_byte  = 1'b1;
				o.res.token_end = 1'b1;
			end else begin
				o.res.text_byte = c;
				o.res.has_byte  = 1'b1;
				o.mode          = MODE_WORD;
			end
		end
		return o;
	endfunction

	// Saturating position advance for the current byte
	always_comb begin
		is_lf    = data_byte == CH_LF;
		line_adv = line_q;
		col_adv  = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
		if (is_lf) begin
			line_adv = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
			col_adv  = COLUMN_BITS'(1);
		end
	end

	assign idle_r = idle_step(data_byte, line_q, col_q);

	always_comb begin
		case (data_byte)
			CH_LOW_N: esc_byte = CH_LF;
			CH_LOW_T: esc_byte = CH_TAB;
			default:  esc_byte = data_byte;
		endcase
	end

	// Mode update and result assembly
	always_comb begin
		mode_d = mode_q;
		line_d = line_adv;
		col_d  = col_adv;
		r0     = '0;
		r1     = '0;
		cnt    = 2'd0;
		if (end_of_input || data_byte == CH_NUL) begin
			mode_d = MODE_IDLE;
			line_d = LINE_BITS'(1);
			col_d  = COLUMN_BITS'(1);
			if (mode_q == MODE_WORD || mode_q == MODE_STRING || mode_q == MODE_ESCAPE) begin
				r0.token_end = 1'b1;
				r0.quoted    = mode_q != MODE_WORD;
				cnt          = 2'd1;
			end
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (is_lf)
						mode_d = MODE_IDLE;
				end
				MODE_WORD: begin
					if (is_word_delim(data_byte)) begin
						r0.token_end = 1'b1;
						r1           = idle_r.res;
						mode_d       = idle_r.mode;
						cnt          = idle_r.emit ? 2'd2 : 2'd1;
					end else begin
						r0.text_byte = data_byte;
						r0.has_byte  = 1'b1;
						cnt          = 2'd1;
					end
				end
				MODE_STRING: begin
					if (data_byte == CH_QUOTE || is_lf) begin
						r0.token_end = 1'b1;
						r0.quoted    = 1'b1;
						cnt          = 2'd1;
						mode_d       = MODE_IDLE;
					end else if (data_byte == CH_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						r0.text_byte = data_byte;
						r0.has_byte  = 1'b1;
						r0.quoted    = 1'b1;
						cnt          = 2'd1;
					end
				end
				MODE_ESCAPE: begin
					r0.text_byte = esc_byte;
					r0.has_byte  = 1'b1;
					r0.quoted    = 1'b1;
					cnt          = 2'd1;
					mode_d       = MODE_STRING;
				end
				default: begin
					// idle, and any stray code behaves as idle
					r0     = idle_r.res;
					mode_d = idle_r.mode;
					cnt    = idle_r.emit ? 2'd1 : 2'd0;
				end
			endcase
		end
		r0.last = cnt == 2'd1;
		r1.last = cnt == 2'd2;
	end

	assign batch.count = cnt;
	assign batch.r0    = r0;
	assign batch.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= COLUMN_BITS'(1);
		end else if (step) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

endmodule

/* hw/rtl/stt_result_queue.sv */
module stt_result_queue import stt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  stt_batch_t  batch,
	output logic        room,
	output logic        head_valid,
	input  logic        head_ready,
	output stt_result_t head
);

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	stt_result_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [1:0]           n_push;
	logic                 pop;

	assign n_push     = push ? batch.count : 2'd0;
	assign pop        = head_valid && head_ready;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];
	// room for the worst case of two beats from one byte
	assign room       = cnt_q <= CNT_BITS'(QUEUE_DEPTH - 2);
	assign wr_ptr_nx  = wr_ptr_q + QPTR_BITS'(1);

	// Storage write, up to two beats per cycle
	always_ff @(posedge clk) begin
		if (n_push != 2'd0)
			mem_q[wr_ptr_q] <= batch.r0;
		if (n_push == 2'd2)
			mem_q[wr_ptr_nx] <= batch.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			cnt_q <= cnt_q + CNT_BITS'(n_push) - CNT_BITS'(pop);
		end
	end

endmodule

/* hw/rtl/scene_text_tokenizer.sv */
// Channel  Direction  Beat contents
// in_ch    sink       data_byte, end_of_input (one text byte per beat)
// out_ch   source     text_byte, has_byte, token_start/end, quoted, line, column, last
//
// One byte per cycle is accepted while out_ch is not stalled and each byte yields at
// most one result; a byte that yields two results adds an extra output beat, drained
// by a four-entry result queue. A byte waits in the input register while the lexer
// acts on it. Reset is asynchronous: the lexer returns to idle at line 1,
// column 1 and the queue empties. A stall on out_ch backs up through the queue
// and the input register to in_ch.ready; no beat is lost or repeated.
module scene_text_tokenizer import stt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	stt_in_if.sink    in_ch,
	stt_out_if.source out_ch
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	logic        room;
	logic        fire_s1;
	stt_batch_t  batch;
	stt_result_t head;

	assign fire_s1     = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			eoi_s1  <= in_ch.end_of_input;
		end
	end

	stt_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (fire_s1),
		.data_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.batch        (batch)
	);

	stt_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire_s1),
		.batch      (batch),
		.room       (room),
		.head_valid (out_ch.valid),
		.head_ready (out_ch.ready),
		.head       (head)
	);

	assign out_ch.text_byte    = head.text_byte;
	assign out_ch.has_byte     = head.has_byte;
	assign out_ch.token_start  = head.token_start;
	assign out_ch.token_end    = head.token_end;
	assign out_ch.quoted       = head.quoted;
	assign out_ch.token_line   = head.token_line;
	assign out_ch.token_column = head.token_column;
	assign out_ch.last         = head.last;

endmodule

/* test/scene_text_tokenizer_tb.sv */
`timescale 1ns / 100ps

module scene_text_tokenizer_tb;
	import stt_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 200_000;

	typedef enum {WORD_BYTE, STRING_BYTE, COMMENT_BYTE} byte_kind_t;

	// Tracks lexer state and holds the token beats still owed by the block
	class token_scoreboard;
		stt_mode_t              mode;
		logic [LINE_BITS-1:0]   line_no;
		logic [COLUMN_BITS-1:0] col_no;
		stt_result_t            token_beats[$];
		int                     errors;

		function new();
			restart();
			errors = 0;
		endfunction

		function void restart();
			mode = MODE_IDLE;
			line_no = LINE_BITS'(1);
			col_no = COLUMN_BITS'(1);
		endfunction

		static function bit is_blank(logic [7:0] c);
			case (c)
				CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		static function bit ends_word(logic [7:0] c);
			return is_blank(c) || c == CH_QUOTE || c == CH_LBRACK || c == CH_RBRACK ||
				c == CH_HASH;
		endfunction

		// Append one beat at the tail of a beat list
		function void add_beat(ref stt_result_t q[$], input stt_result_t r);
			q.insert(q.size(), r);
		endfunction

		// Saturating line/column update for one consumed byte
		function void step_position(logic [7:0] c);
			if (c == CH_LF) begin
				if (line_no != '1)
					line_no++;
				col_no = COLUMN_BITS'(1);
			end else if (col_no != '1) begin
				col_no++;
			end
		endfunction

		function stt_result_t beat(logic [7:0] text, bit has, bit opens, bit closes, bit q,
				logic [LINE_BITS-1:0] ln, logic [COLUMN_BITS-1:0] col);
			stt_result_t r;
			r.text_byte = text;
			r.has_byte = has;
			r.token_start = opens;
			r.token_end = closes;
			r.quoted = q;
			r.token_line = opens ? ln : '0;
			r.token_column = opens ? col : '0;
			r.last = 1'b0;
			return r;
		endfunction

		// Byte seen between tokens: skip, start a comment, or open a token
		function void open_token(logic [7:0] c, ref stt_result_t beats[$]);
			logic [LINE_BITS-1:0]   ln;
			logic [COLUMN_BITS-1:0] col;
			ln = line_no;
			col = col_no;
			step_position(c);
			mode = MODE_IDLE;
			if (is_blank(c)) begin
				return;
			end else if (c == CH_HASH) begin
				mode = MODE_COMMENT;
			end else if (c == CH_QUOTE) begin
				add_beat(beats, beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, ln, col));
				mode = MODE_STRING;
			end else if (c == CH_LBRACK || c == CH_RBRACK) begin
				add_beat(beats, beat(c, 1'b1, 1'b1, 1'b1, 1'b0, ln, col));
			end else begin
				add_beat(beats, beat(c, 1'b1, 1'b1, 1'b0, 1'b0, ln, col));
				mode = MODE_WORD;
			end
		endfunction

		// Work out the beats caused by one accepted input beat
		function void note_byte(logic [7:0] c, logic eoi);
			stt_result_t beats[$];
			logic [7:0]  t;
			if (eoi || c == CH_NUL) begin
				if (mode == MODE_WORD || mode == MODE_STRING || mode == MODE_ESCAPE)
					add_beat(beats, beat(8'h00, 1'b0, 1'b0, 1'b1, mode != MODE_WORD,
						'0, '0));
				restart();
			end else begin
				case (mode)
					MODE_COMMENT: begin
						step_position(c);
						if (c == CH_LF)
							mode = MODE_IDLE;
					end
					MODE_WORD: begin
						if (ends_word(c)) begin
							add_beat(beats, beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0));
							open_token(c, beats);
						end else begin
							step_position(c);
							add_beat(beats, beat(c, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0));
						end
					end
					MODE_STRING: begin
						step_position(c);
						if (c == CH_QUOTE || c == CH_LF) begin
							add_beat(beats, beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, '0, '0));
							mode = MODE_IDLE;
						end else if (c == CH_BSLASH) begin
							mode = MODE_ESCAPE;
						end else begin
							add_beat(beats, beat(c, 1'b1, 1'b0, 1'b0, 1'b1, '0, '0));
						end
					end
					MODE_ESCAPE: begin
						step_position(c);
						t = (c == CH_LOW_N) ? CH_LF : (c == CH_LOW_T) ? CH_TAB : c;
						add_beat(beats, beat(t, 1'b1, 1'b0, 1'b0, 1'b1, '0, '0));
						mode = MODE_STRING;
					end
					default: open_token(c, beats);
				endcase
			end
			if (beats.size() > 0)
				beats[beats.size()-1].last = 1'b1;
			foreach (beats[i])
				add_beat(token_beats, beats[i]);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_beat(stt_result_t got);
			stt_result_t want;
			if (token_beats.size() == 0) begin
				$error("result beat with nothing expected: 0x%0h", got);
				errors++;
				return;
			end
			want = token_beats.pop_front();
			compare("text_byte", want.text_byte, got.text_byte);
			compare("has_byte", want.has_byte, got.has_byte);
			compare("token_start", want.token_start, got.token_start);
			compare("token_end", want.token_end, got.token_end);
			compare("quoted", want.quoted, got.quoted);
			compare("token_line", want.token_line, got.token_line);
			compare("token_column", want.token_column, got.token_column);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	stt_in_if  in_ch();
	stt_out_if out_ch();

	scene_text_tokenizer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	token_scoreboard sb = new();

	bit     sender_gaps = 1'b0;
	bit     receiver_stalls = 1'b0;
	bit     long_hold = 1'b0;
	int     bytes_sent = 0;
	longint cycle_count = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Observe both channels at each edge
	always @(posedge clk) begin : observe
		stt_result_t got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.text_byte = out_ch.text_byte;
				got.has_byte = out_ch.has_byte;
				got.token_start = out_ch.token_start;
				got.token_end = out_ch.token_end;
				got.quoted = out_ch.quoted;
				got.token_line = out_ch.token_line;
				got.token_column = out_ch.token_column;
				got.last = out_ch.last;
				sb.check_beat(got);
			end
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.data_byte, in_ch.end_of_input);
		end
	end

	// Result side: random stall bursts, and one long hold-off on request
	initial begin : receiver
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one byte beat and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		if (sender_gaps && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_of_input <= eoi;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_byte(byte_kind_t kind);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while ((kind == WORD_BYTE && token_scoreboard::ends_word(c)) ||
			(kind == STRING_BYTE && (c == CH_QUOTE || c == CH_LF || c == CH_BSLASH)) ||
			(kind == COMMENT_BYTE && c == CH_LF));
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	// One random fragment of source text, mostly well formed
	task automatic random_fragment();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, 8);
		if (pick < 25) begin
			// bare word
			repeat (n + 1) send_byte(pick_byte(WORD_BYTE), 1'b0);
		end else if (pick < 45) begin
			// quoted string with escapes
			send_byte(CH_QUOTE, 1'b0);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					send_byte(CH_BSLASH, 1'b0);
					case ($urandom_range(0, 4))
						0: send_byte(CH_LOW_N, 1'b0);
						1: send_byte(CH_LOW_T, 1'b0);
						2: send_byte(CH_BSLASH, 1'b0);
						3: send_byte(CH_LF, 1'b0);
						default: send_byte(pick_byte(STRING_BYTE), 1'b0);
					endcase
				end else begin
					send_byte(pick_byte(STRING_BYTE), 1'b0);
				end
			end
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom_range(0, 255)), 1'b1);
				1: begin
					send_byte(CH_BSLASH, 1'b0);
					send_byte(CH_NUL, 1'b0);
				end
				2, 3: send_byte(CH_LF, 1'b0);
				default: send_byte(CH_QUOTE, 1'b0);
			endcase
		end else if (pick < 55) begin
			send_byte($urandom_range(0, 1) ? CH_LBRACK : CH_RBRACK, 1'b0);
		end else if (pick < 65) begin
			// comment to end of line, sometimes cut by end of input
			send_byte(CH_HASH, 1'b0);
			repeat (n) send_byte(pick_byte(COMMENT_BYTE), 1'b0);
			if ($urandom_range(0, 9) == 0)
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			else
				send_byte(CH_LF, 1'b0);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 3)) send_byte(pick_blank(), 1'b0);
		end else if (pick < 95) begin
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end else if ($urandom_range(0, 1) == 0) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_byte(CH_NUL, 1'b0);
		end
	endtask

	// A bracket that closes a word gives two beats; with the sink held off the block backs up
	task automatic fill_while_held();
		long_hold = 1'b1;
		repeat (40) begin
			send_byte("a", 1'b0);
			send_byte(CH_RBRACK, 1'b0);
		end
	endtask

	initial begin : stimulus
		int phase_end;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.end_of_input <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: skipped blanks, brackets, words, comments, strings, escapes, endings
		send_byte(CH_VT, 1'b0);
		send_byte(CH_FF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_text("[]w");
		send_byte(8'hFF, 1'b0);
		send_text("#z\na\"\\n\\t\\\\\\");
		send_byte(CH_LF, 1'b0);
		send_text("\\q\n");
		send_text("\"\\");
		send_byte(8'hA5, 1'b1);
		send_text("b");
		send_byte(CH_NUL, 1'b0);

		// Random text with idling switched per block
		for (int blk = 0; blk < 4; blk++) begin
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			phase_end = bytes_sent + 100;
			while (bytes_sent < phase_end)
				random_fragment();
			if (blk == 1)
				fill_while_held();
		end

		// Last stretch at full rate
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		phase_end = bytes_sent + 100;
		while (bytes_sent < phase_end)
			random_fragment();
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (sb.token_beats.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.token_beats.size() != 0) begin
			$error("result beats still owed at end: %0d", sb.token_beats.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* scene_text_tokenizer.f */
hw/rtl/stt_pkg.sv
hw/rtl/stt_in_if.sv
hw/rtl/stt_out_if.sv
hw/rtl/stt_lexer.sv
hw/rtl/stt_result_queue.sv
hw/rtl/scene_text_tokenizer.sv
test/scene_text_tokenizer_tb.sv
